/* rtl/mls_pkg.sv */
// Package for the motor lock sequencer: phase and event codes, register indexes,
// the configuration and result structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mls_pkg;

  typedef enum logic [1:0] {
    PH_CLOSING = 2'd0,
    PH_CLOSED  = 2'd1,
    PH_OPENING = 2'd2,
    PH_OPEN    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_OPEN_LIMIT   = 3'd1,
    EV_OPEN_TIMEOUT = 3'd2,
    EV_CLOSED       = 3'd3,
    EV_OPENING      = 3'd4,
    EV_CLOSING      = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE      = 2'd0,
    REG_OPEN_TIMEOUT  = 2'd1,
    REG_CLOSE_TIMEOUT = 2'd2,
    REG_DRIVE_DUTY    = 2'd3
  } reg_idx_t;

  localparam logic [15:0] DEBOUNCE_RESET      = 16'd50;
  localparam logic [15:0] OPEN_TIMEOUT_RESET  = 16'd5000;
  localparam logic [15:0] CLOSE_TIMEOUT_RESET = 16'd3000;
  localparam logic [7:0]  DRIVE_DUTY_RESET    = 8'd200;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] open_timeout_ms;
    logic [15:0] close_timeout_ms;
    logic [7:0]  drive_duty;
  } cfg_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       unlocked;
    logic [1:0] lock_phase;
    logic [7:0] duty_close_leg;
    logic [7:0] duty_open_leg;
  } result_t;

endpackage

`default_nettype wire

/* rtl/mls_core.sv */
// Debouncer and lock phase sequencer with their state registers.
// Depends on mls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mls_core #(
  parameter int TIMER_WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [9:0]       delta_ms,
  input  wire logic             limit_level,
  input  wire logic             open_req,
  input  wire logic             close_req,
  input  wire mls_pkg::cfg_t    cfg,
  output mls_pkg::result_t      result
);

  localparam int SUM_W = ((TIMER_WIDTH > 10) ? TIMER_WIDTH : 10) + 1;
  localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

  mls_pkg::phase_t          phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0]   phase_elapsed_r, phase_elapsed_nxt;
  logic [TIMER_WIDTH-1:0]   settle_elapsed_r, settle_elapsed_nxt;
  logic                     limit_previous_r, limit_previous_nxt;
  logic                     limit_settled_r, limit_settled_nxt;

  logic                     reading;
  logic [SUM_W-1:0]         settle_sum, phase_sum;
  logic [TIMER_WIDTH-1:0]   settle_inc, phase_inc;
  logic                     settled_now;
  logic                     close_done, open_done;
  logic [7:0]               open_leg, close_leg;
  mls_pkg::event_t          ev;

  assign reading    = ~limit_level;
  assign settle_sum = SUM_W'(settle_elapsed_r) + SUM_W'(delta_ms);
  assign phase_sum  = SUM_W'(phase_elapsed_r) + SUM_W'(delta_ms);
  assign settle_inc = (settle_sum > SUM_W'(TIMER_MAX)) ? TIMER_MAX
                                                       : settle_sum[TIMER_WIDTH-1:0];
  assign phase_inc  = (phase_sum > SUM_W'(TIMER_MAX)) ? TIMER_MAX
                                                      : phase_sum[TIMER_WIDTH-1:0];

  logic [TIMER_WIDTH-1:0] settle_new;
  assign settle_new  = (reading != limit_previous_r) ? '0 : settle_inc;
  assign settled_now = (CMP_W'(settle_new) >= CMP_W'(cfg.debounce_ms)) ? reading
                                                                       : limit_settled_r;
  assign close_done  = CMP_W'(phase_inc) >= CMP_W'(cfg.close_timeout_ms);
  assign open_done   = CMP_W'(phase_inc) >= CMP_W'(cfg.open_timeout_ms);

  always_comb begin
    phase_nxt          = phase_r;
    phase_elapsed_nxt  = phase_inc;
    settle_elapsed_nxt = settle_new;
    limit_previous_nxt = reading;
    limit_settled_nxt  = settled_now;
    unique case (phase_r)
      mls_pkg::PH_CLOSING: begin
        if (close_done) begin
          phase_nxt         = mls_pkg::PH_CLOSED;
          phase_elapsed_nxt = '0;
        end
      end
      mls_pkg::PH_CLOSED: begin
        if (open_req) begin
          phase_nxt          = mls_pkg::PH_OPENING;
          phase_elapsed_nxt  = '0;
          settle_elapsed_nxt = '0;
          limit_previous_nxt = 1'b0;
          limit_settled_nxt  = 1'b0;
        end
      end
      mls_pkg::PH_OPENING: begin
        if (settled_now || open_done) begin
          phase_nxt         = mls_pkg::PH_OPEN;
          phase_elapsed_nxt = '0;
        end
      end
      mls_pkg::PH_OPEN: begin
        if (close_req) begin
          phase_nxt         = mls_pkg::PH_CLOSING;
          phase_elapsed_nxt = '0;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  always_comb begin
    open_leg  = 8'd0;
    close_leg = 8'd0;
    ev        = mls_pkg::EV_NONE;
    unique case (phase_r)
      mls_pkg::PH_CLOSING: begin
        if (close_done) begin
          ev = mls_pkg::EV_CLOSED;
        end else begin
          close_leg = cfg.drive_duty;
        end
      end
      mls_pkg::PH_CLOSED: begin
        if (open_req) begin
          ev = mls_pkg::EV_OPENING;
        end
      end
      mls_pkg::PH_OPENING: begin
        if (settled_now) begin
          ev = mls_pkg::EV_OPEN_LIMIT;
        end else if (open_done) begin
          ev = mls_pkg::EV_OPEN_TIMEOUT;
        end else begin
          open_leg = cfg.drive_duty;
        end
      end
      mls_pkg::PH_OPEN: begin
        if (close_req) begin
          ev = mls_pkg::EV_CLOSING;
        end
      end
      default: begin
        ev = mls_pkg::EV_NONE;
      end
    endcase
  end

  assign result.duty_open_leg  = open_leg;
  assign result.duty_close_leg = close_leg;
  assign result.lock_phase     = phase_nxt;
  assign result.unlocked       = (phase_nxt == mls_pkg::PH_OPENING) ||
                                 (phase_nxt == mls_pkg::PH_OPEN);
  assign result.event_code     = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= mls_pkg::PH_OPENING;
      phase_elapsed_r  <= '0;
      settle_elapsed_r <= '0;
      limit_previous_r <= 1'b0;
      limit_settled_r  <= 1'b0;
    end else if (step) begin
      phase_r          <= phase_nxt;
      phase_elapsed_r  <= phase_elapsed_nxt;
      settle_elapsed_r <= settle_elapsed_nxt;
      limit_previous_r <= limit_previous_nxt;
      limit_settled_r  <= limit_settled_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/motor_lock_sequencer.sv */
// Output: a result is valid in the cycle after its poll transaction is accepted while the
// output register is free or draining; a poll taken during an output stall waits longer.
// Throughput: one poll per cycle; the debouncer and sequencer finish a poll in one pass of
// logic, and a second output entry takes one more poll while a result waits, after which
// in_tready drops until the output drains. Synchronous active-low reset restores the
// register defaults, puts the lock in the opening phase with cleared timers, empties buffer.
`timescale 1ns / 1ps
`default_nettype none

module motor_lock_sequencer #(
  parameter int TIMER_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // [9:0] delta_ms, [10] limit_level, [11] open_req, [12] close_req, [15:13] zero
  input  wire logic [15:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] duty_open_leg, [15:8] duty_close_leg, [17:16] lock_phase,
  // [18] unlocked, [21:19] event_code, [23:22] zero
  output logic [23:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  mls_pkg::cfg_t    cfg_r;
  mls_pkg::result_t res;
  mls_pkg::result_t out_r, skid_r;
  logic             out_valid_r, skid_valid_r;
  logic             in_fire, out_fire, cfg_write;
  mls_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = mls_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms      <= mls_pkg::DEBOUNCE_RESET;
      cfg_r.open_timeout_ms  <= mls_pkg::OPEN_TIMEOUT_RESET;
      cfg_r.close_timeout_ms <= mls_pkg::CLOSE_TIMEOUT_RESET;
      cfg_r.drive_duty       <= mls_pkg::DRIVE_DUTY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        mls_pkg::REG_DEBOUNCE:      cfg_r.debounce_ms      <= cfg_pwdata[15:0];
        mls_pkg::REG_OPEN_TIMEOUT:  cfg_r.open_timeout_ms  <= cfg_pwdata[15:0];
        mls_pkg::REG_CLOSE_TIMEOUT: cfg_r.close_timeout_ms <= cfg_pwdata[15:0];
        mls_pkg::REG_DRIVE_DUTY:    cfg_r.drive_duty       <= cfg_pwdata[7:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      mls_pkg::REG_DEBOUNCE:      cfg_prdata = {16'd0, cfg_r.debounce_ms};
      mls_pkg::REG_OPEN_TIMEOUT:  cfg_prdata = {16'd0, cfg_r.open_timeout_ms};
      mls_pkg::REG_CLOSE_TIMEOUT: cfg_prdata = {16'd0, cfg_r.close_timeout_ms};
      mls_pkg::REG_DRIVE_DUTY:    cfg_prdata = {24'd0, cfg_r.drive_duty};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  mls_core #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_fire),
    .delta_ms    (in_tdata[9:0]),
    .limit_level (in_tdata[10]),
    .open_req    (in_tdata[11]),
    .close_req   (in_tdata[12]),
    .cfg         (cfg_r),
    .result      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire && out_valid_r && !out_tready) begin
      skid_valid_r <= 1'b1;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire && out_valid_r && !out_tready) begin
      skid_r <= res;
    end else if (in_fire) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_open_drive_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[7:0] != 8'd0)) |->
    ((out_tdata[17:16] == mls_pkg::PH_OPENING) && (out_tdata[15:8] == 8'd0)))
    else $error("opening leg driven outside the opening phase");

  a_closed_event_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[21:19] == mls_pkg::EV_CLOSED)) |->
    ((out_tdata[17:16] == mls_pkg::PH_CLOSED) && !out_tdata[18]))
    else $error("closed event reported with wrong phase");

endmodule

`default_nettype wire
